/* rtl/timed_event_priority_queue_core_defines.svh */
// Assertion macros for the timed event priority queue core.
// Included by the modules that assert; no other dependencies.
`ifndef TIMED_EVENT_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TEPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TEPQ_CHECK(lbl, clk, rst, expr, msg) \
  `TEPQ_ASSERT(lbl, clk, rst, (expr), msg)
`else
`define TEPQ_ASSERT(lbl, clk, rst, prop, msg)
`define TEPQ_CHECK(lbl, clk, rst, expr, msg)
`endif
`endif

/* rtl/tepq_pkg.sv */
// Shared constants, codes and entry type of the timed event priority queue.
// No dependencies.
package tepq_pkg;
  localparam int QUEUE_DEPTH = 64;
  localparam int ID_COUNT    = 256;
  localparam int TIME_BITS   = 32;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = $clog2(ID_COUNT);

  localparam logic [1:0] KIND_SCHED   = 2'd0;
  localparam logic [1:0] KIND_UNSCHED = 2'd1;
  localparam logic [1:0] KIND_RESCHED = 2'd2;
  localparam logic [1:0] KIND_POP     = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_QUEUED     = 3'd1;
  localparam logic [2:0] ST_NOT_QUEUED = 3'd2;
  localparam logic [2:0] ST_WINDOW     = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_EMPTY      = 3'd5;

  localparam logic [31:0] END_TIME_RESET = 32'd13107200;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [TIME_BITS-1:0] tm;
  } entry_t;
endpackage

/* rtl/tepq_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module tepq_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 40,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

/* rtl/timed_event_priority_queue_core.sv */
// Timed event priority queue: sorted entries in a RAM, id flags in a second RAM.
// One request in flight; the next is taken in the cycle after its result is issued.
// Sync reset clears count and current time and sets end time (200.0 s); a pass over all 256 ids clears flags.
// Depends on tepq_pkg, tepq_ram and timed_event_priority_queue_core_defines.svh.
`include "timed_event_priority_queue_core_defines.svh"
module timed_event_priority_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  event_id,
  input  logic [31:0] event_time,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  out_id,
  output logic [31:0] out_time,
  output logic [6:0]  queued_count
);
  import tepq_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_DEL_RD, S_DEL_CMP, S_SCHED_CHK, S_INS_RD, S_INS_CMP, S_FIN
  } state_t;

  state_t               state;
  logic [1:0]           op;
  logic [ID_W-1:0]      rid;
  logic [TIME_BITS-1:0] rtm;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     count;
  logic                 found;
  logic [ID_W-1:0]      clr_idx;
  logic [TIME_BITS-1:0] cur_time;
  logic [31:0]          horizon;
  logic [2:0]           res_status;
  logic [7:0]           res_id;
  logic [31:0]          res_time;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  entry_t               mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  entry_t               rdata;
  logic                 match;
  logic [CNT_W-1:0]     idx_m1;

  logic                 flag_mem [ID_COUNT];
  logic                 flag_we;
  logic [ID_W-1:0]      flag_waddr;
  logic                 flag_wdata;
  logic [ID_W-1:0]      flag_raddr;
  logic                 flag_rd;

  assign in_stall = (state != S_IDLE);
  assign idx_m1   = idx - CNT_W'(1);
  assign match    = (op == KIND_POP) ? (idx == '0) : (rdata.id == rid);

  tepq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(entry_t))) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // RAM port control: shift down on delete, shift up or place on insert
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[ADDR_W-1:0];
    mem_wdata = rdata;
    mem_raddr = idx[ADDR_W-1:0];
    case (state)
      S_DEL_CMP: begin
        mem_we    = found;
        mem_waddr = idx_m1[ADDR_W-1:0];
      end
      S_INS_RD: begin
        mem_raddr = idx_m1[ADDR_W-1:0];
        if (idx == '0) begin
          mem_we    = 1'b1;
          mem_wdata = '{id: rid, tm: rtm};
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (!(rdata.tm > rtm)) begin
          mem_wdata = '{id: rid, tm: rtm};
        end
      end
      default: ;
    endcase
  end

  // Flag port control: clear after reset, look up the request id, set or drop flags
  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = rid;
    flag_wdata = 1'b0;
    flag_raddr = rid;
    case (state)
      S_CLEAR: begin
        flag_we    = 1'b1;
        flag_waddr = clr_idx;
      end
      S_IDLE: begin
        flag_raddr = event_id[ID_W-1:0];
      end
      S_CHECK: begin
        flag_we = (op inside {KIND_UNSCHED, KIND_RESCHED}) && flag_rd;
      end
      S_DEL_CMP: begin
        if (op == KIND_POP && !found && match) begin
          flag_we    = 1'b1;
          flag_waddr = rdata.id;
        end
      end
      S_INS_RD: begin
        if (idx == '0) begin
          flag_we    = 1'b1;
          flag_wdata = 1'b1;
        end
      end
      S_INS_CMP: begin
        if (!(rdata.tm > rtm)) begin
          flag_we    = 1'b1;
          flag_wdata = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Id flag memory with registered read
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rd <= flag_mem[flag_raddr];
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      cur_time  <= '0;
      horizon   <= END_TIME_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        horizon <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + ID_W'(1);
          if (clr_idx == ID_W'(ID_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op       <= kind;
            rid      <= event_id[ID_W-1:0];
            rtm      <= event_time[TIME_BITS-1:0];
            res_id   <= event_id;
            res_time <= '0;
            idx      <= '0;
            found    <= 1'b0;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          case (op)
            KIND_SCHED: begin
              if (flag_rd) begin
                res_status <= ST_QUEUED;
                state      <= S_FIN;
              end else begin
                state <= S_SCHED_CHK;
              end
            end
            KIND_POP: begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_FIN;
              end else begin
                state <= S_DEL_RD;
              end
            end
            default: begin
              if (!flag_rd) begin
                res_status <= ST_NOT_QUEUED;
                state      <= S_FIN;
              end else begin
                state <= S_DEL_RD;
              end
            end
          endcase
        end
        S_DEL_RD: begin
          if (idx == count) begin
            count <= count - CNT_W'(1);
            if (op == KIND_RESCHED) begin
              state <= S_SCHED_CHK;
            end else begin
              res_status <= ST_OK;
              state      <= S_FIN;
            end
          end else begin
            state <= S_DEL_CMP;
          end
        end
        S_DEL_CMP: begin
          if (!found && match) begin
            found <= 1'b1;
            if (op == KIND_POP) begin
              res_id   <= 8'(rdata.id);
              res_time <= 32'(rdata.tm);
              cur_time <= rdata.tm;
            end
          end
          idx   <= idx + CNT_W'(1);
          state <= S_DEL_RD;
        end
        S_SCHED_CHK: begin
          if ((32'(rtm) > horizon) || (rtm < cur_time)) begin
            res_status <= ST_WINDOW;
            state      <= S_FIN;
          end else if (count >= CNT_W'(QUEUE_DEPTH)) begin
            res_status <= ST_FULL;
            state      <= S_FIN;
          end else begin
            idx   <= count;
            state <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          if (idx == '0) begin
            count      <= count + CNT_W'(1);
            res_status <= ST_OK;
            state      <= S_FIN;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rdata.tm > rtm) begin
            idx   <= idx_m1;
            state <= S_INS_RD;
          end else begin
            count      <= count + CNT_W'(1);
            res_status <= ST_OK;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            out_id       <= res_id;
            out_time     <= res_time;
            queued_count <= 7'(count);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TEPQ_CHECK(a_count_bound, clk, rst, count <= CNT_W'(QUEUE_DEPTH), "count over depth")
  `TEPQ_ASSERT(a_req_starts, clk, rst, in_valid && !in_stall |=> state != S_IDLE, "request dropped")
  `TEPQ_ASSERT(a_out_from_fin, clk, rst, $rose(out_valid) |-> $past(state == S_FIN), "stray result")
  `TEPQ_ASSERT(a_ins_idx, clk, rst, state == S_INS_RD |-> idx <= count, "insert index past count")
endmodule
